// ----- hdl/arp_hp_pkg.sv -----
// Package for the ARP header parser: shared constants, codes and word types.
// No dependencies; imported by arp_header_parser.
`default_nettype none

package arp_hp_pkg;

  // Width of the per-packet byte counter; it saturates at its all-ones value.
  localparam int unsigned COUNT_WIDTH = 11;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Fixed part of the ARP header, in bytes, and its field offsets.
  localparam logic [COUNT_WIDTH-1:0] HDR_LEN      = COUNT_WIDTH'(8);
  localparam logic [COUNT_WIDTH-1:0] POS_HTYPE_HI = COUNT_WIDTH'(0);
  localparam logic [COUNT_WIDTH-1:0] POS_HTYPE_LO = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] POS_PTYPE_HI = COUNT_WIDTH'(2);
  localparam logic [COUNT_WIDTH-1:0] POS_PTYPE_LO = COUNT_WIDTH'(3);
  localparam logic [COUNT_WIDTH-1:0] POS_HLEN     = COUNT_WIDTH'(4);
  localparam logic [COUNT_WIDTH-1:0] POS_PLEN     = COUNT_WIDTH'(5);
  localparam logic [COUNT_WIDTH-1:0] POS_OP_HI    = COUNT_WIDTH'(6);
  localparam logic [COUNT_WIDTH-1:0] POS_OP_LO    = COUNT_WIDTH'(7);

  // Expected header values.
  localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  HLEN_ETHERNET  = 8'd6;
  localparam logic [7:0]  PLEN_IPV4      = 8'd4;
  localparam logic [15:0] OP_REQUEST     = 16'h0001;
  localparam logic [15:0] OP_REPLY       = 16'h0002;

  // Result kinds.
  localparam logic KIND_ADDR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Address selectors.
  localparam logic [1:0] SEL_SENDER_HW    = 2'd0;
  localparam logic [1:0] SEL_SENDER_PROTO = 2'd1;
  localparam logic [1:0] SEL_TARGET_HW    = 2'd2;
  localparam logic [1:0] SEL_TARGET_PROTO = 2'd3;

  // Error bit positions.
  localparam int unsigned ERR_W         = 7;
  localparam int unsigned ERR_HW_TYPE   = 0;
  localparam int unsigned ERR_PROTO     = 1;
  localparam int unsigned ERR_HLEN      = 2;
  localparam int unsigned ERR_PLEN      = 3;
  localparam int unsigned ERR_OP        = 4;
  localparam int unsigned ERR_PAY_SHORT = 5;
  localparam int unsigned ERR_HDR_SHORT = 6;

  // Result queue: room for two results per byte plus slack for a stalled receiver.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } arp_in_t;

  typedef struct packed {
    logic             kind;
    logic [1:0]       addr_select;
    logic [7:0]       addr_index;
    logic [7:0]       addr_byte;
    logic [15:0]      hw_type;
    logic [15:0]      proto_type;
    logic [15:0]      op_code;
    logic [7:0]       hw_len;
    logic [7:0]       proto_len;
    logic [ERR_W-1:0] error_bits;
    logic             last_result;
  } arp_out_t;

endpackage

`default_nettype wire

// ----- hdl/arp_header_parser.sv -----
// ARP header parser top level: byte-wise header capture, address tagging and summary.
// Depends on arp_hp_pkg for constants, codes and the word types.
`default_nettype none

// Usage
// The input channel (in_valid, in_ready, in_data) carries one packet byte per word,
// starting at the first byte of the ARP header, with end_of_packet set on the last
// byte. The output channel (out_valid, out_ready, out_data) carries result words:
// one per address byte of the four addresses, and a summary on the last byte with
// the header fields and error bits. One input word gives zero, one or two results.
// An accepted word is registered, then processed into a four-entry result queue once
// the queue has room for it; its first result can then be taken from the queue.
// Throughput: one input word per cycle while the receiver keeps up; the input side
// needs two free queue places, so a byte that yields address and summary together
// leaves two result words for the receiver to drain.
// When the receiver stalls, the queue fills and in_ready drops; nothing is lost.
// cfg_wr_en and cfg_wr_data write the quick-parse bit, which must only change while
// the block is idle. Reset (rst_n low, synchronous) empties the input register and
// the queue, clears quick-parse and starts a fresh packet.
module arp_header_parser
  import arp_hp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire arp_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output arp_out_t      out_data
);

  // Configuration.
  logic quick_parse_r;

  // Input register.
  logic    in_v_r;
  arp_in_t in_d_r;

  // Per-packet state.
  logic [COUNT_WIDTH-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]            hw_type_r, hw_type_nxt;
  logic [15:0]            proto_type_r, proto_type_nxt;
  logic [15:0]            op_r, op_nxt;
  logic [7:0]             hw_len_r, hw_len_nxt;
  logic [7:0]             proto_len_r, proto_len_nxt;

  // Result queue.
  arp_out_t            q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   q_wr_r, q_rd_r;
  logic [QCNT_W-1:0]   q_cnt_r;

  logic     pop, advance;
  logic     has_addr, has_sum;
  arp_out_t res_addr, res_sum, first_res;
  logic [1:0] n_push;

  // Address decode.
  logic [COUNT_WIDTH-1:0] pos, off, hl_x, pl_x, b1, b2, b3, b4, need, len;
  logic                   in_addr;

  assign pop = out_valid && out_ready;
  // The registered word moves on when the queue has two places, counting a pop now.
  assign advance = in_v_r && ((q_cnt_r < QCNT_W'(QDEPTH - 1)) ||
                              (pop && (q_cnt_r < QCNT_W'(QDEPTH))));
  assign in_ready = !in_v_r || advance;

  assign out_valid = (q_cnt_r != '0);
  assign out_data  = q_mem_r[q_rd_r];

  // Boundaries of the four addresses, measured from the end of the fixed header.
  assign pos  = byte_count_r;
  assign off  = pos - HDR_LEN;
  assign hl_x = COUNT_WIDTH'(hw_len_r);
  assign pl_x = COUNT_WIDTH'(proto_len_r);
  assign b1   = hl_x;
  assign b2   = hl_x + pl_x;
  assign b3   = (hl_x << 1) + pl_x;
  assign b4   = (hl_x << 1) + (pl_x << 1);
  assign in_addr = (pos >= HDR_LEN) && (off < b4);

  // Header capture and the saturating counter.
  always_comb begin
    hw_type_nxt    = hw_type_r;
    proto_type_nxt = proto_type_r;
    op_nxt         = op_r;
    hw_len_nxt     = hw_len_r;
    proto_len_nxt  = proto_len_r;
    case (pos)
      POS_HTYPE_HI: hw_type_nxt[15:8]    = in_d_r.data_byte;
      POS_HTYPE_LO: hw_type_nxt[7:0]     = in_d_r.data_byte;
      POS_PTYPE_HI: proto_type_nxt[15:8] = in_d_r.data_byte;
      POS_PTYPE_LO: proto_type_nxt[7:0]  = in_d_r.data_byte;
      POS_HLEN:     hw_len_nxt           = in_d_r.data_byte;
      POS_PLEN:     proto_len_nxt        = in_d_r.data_byte;
      POS_OP_HI:    op_nxt[15:8]         = in_d_r.data_byte;
      POS_OP_LO:    op_nxt[7:0]          = in_d_r.data_byte;
      default:      ;
    endcase
    byte_count_nxt = (byte_count_r == COUNT_MAX) ? byte_count_r
                                                 : byte_count_r + COUNT_WIDTH'(1);
  end

  // Address byte result.
  always_comb begin
    res_addr             = '0;
    res_addr.kind        = KIND_ADDR;
    res_addr.addr_byte   = in_d_r.data_byte;
    res_addr.last_result = !in_d_r.end_of_packet;
    if (off < b1) begin
      res_addr.addr_select = SEL_SENDER_HW;
      res_addr.addr_index  = off[7:0];
    end else if (off < b2) begin
      res_addr.addr_select = SEL_SENDER_PROTO;
      res_addr.addr_index  = 8'(off - b1);
    end else if (off < b3) begin
      res_addr.addr_select = SEL_TARGET_HW;
      res_addr.addr_index  = 8'(off - b2);
    end else begin
      res_addr.addr_select = SEL_TARGET_PROTO;
      res_addr.addr_index  = 8'(off - b3);
    end
    has_addr = in_addr;
  end

  // End-of-packet summary, built from the header as it stands after this byte.
  assign len  = byte_count_nxt;
  assign need = HDR_LEN + b4;

  always_comb begin
    res_sum             = '0;
    res_sum.kind        = KIND_SUMMARY;
    res_sum.last_result = 1'b1;
    if (len < HDR_LEN) begin
      res_sum.error_bits[ERR_HDR_SHORT] = 1'b1;
    end else begin
      res_sum.hw_type    = hw_type_nxt;
      res_sum.proto_type = proto_type_nxt;
      res_sum.op_code    = op_nxt;
      res_sum.hw_len     = hw_len_nxt;
      res_sum.proto_len  = proto_len_nxt;
      if (!quick_parse_r) begin
        res_sum.error_bits[ERR_HW_TYPE]   = (hw_type_nxt != HTYPE_ETHERNET);
        res_sum.error_bits[ERR_PROTO]     = (proto_type_nxt != PTYPE_IPV4);
        res_sum.error_bits[ERR_HLEN]      = (hw_len_nxt != HLEN_ETHERNET);
        res_sum.error_bits[ERR_PLEN]      = (proto_len_nxt != PLEN_IPV4);
        res_sum.error_bits[ERR_OP]        = (op_nxt != OP_REQUEST) && (op_nxt != OP_REPLY);
        res_sum.error_bits[ERR_PAY_SHORT] = (len < need);
      end
    end
    has_sum = in_d_r.end_of_packet;
  end

  assign first_res = has_addr ? res_addr : res_sum;
  assign n_push    = advance ? (2'(has_addr) + 2'(has_sum)) : 2'd0;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quick_parse_r <= 1'b0;
      in_v_r        <= 1'b0;
      byte_count_r  <= '0;
      hw_type_r     <= '0;
      proto_type_r  <= '0;
      op_r          <= '0;
      hw_len_r      <= '0;
      proto_len_r   <= '0;
      q_wr_r        <= '0;
      q_rd_r        <= '0;
      q_cnt_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        quick_parse_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        if (in_d_r.end_of_packet) begin
          // A new packet starts with the next byte.
          byte_count_r <= '0;
          hw_type_r    <= '0;
          proto_type_r <= '0;
          op_r         <= '0;
          hw_len_r     <= '0;
          proto_len_r  <= '0;
        end else begin
          byte_count_r <= byte_count_nxt;
          hw_type_r    <= hw_type_nxt;
          proto_type_r <= proto_type_nxt;
          op_r         <= op_nxt;
          hw_len_r     <= hw_len_nxt;
          proto_len_r  <= proto_len_nxt;
        end
      end
      q_wr_r  <= q_wr_r + QPTR_W'(n_push);
      q_rd_r  <= q_rd_r + QPTR_W'(pop);
      q_cnt_r <= q_cnt_r + QCNT_W'(n_push) - QCNT_W'(pop);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_d_r <= in_data;
    end
    if (n_push != 2'd0) begin
      q_mem_r[q_wr_r] <= first_res;
    end
    if (n_push == 2'd2) begin
      q_mem_r[q_wr_r + QPTR_W'(1)] <= res_sum;
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for arp_header_parser: random and directed ARP packets
// against a byte-level predictor held in a small scoreboard class.
// Depends on arp_hp_pkg and arp_header_parser only.
`timescale 1ns / 100ps

module tb;
  import arp_hp_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  // Predicts the result words of the parser from the bytes it accepts, and checks
  // each result word that leaves the block against the oldest prediction.
  class arp_result_tracker;
    bit                     quick_parse;
    logic [COUNT_WIDTH-1:0] seen_bytes;
    logic [15:0]            htype, ptype, opcode;
    logic [7:0]             hlen, plen;
    arp_out_t               due[$];
    int unsigned            mismatches;

    function void clear_packet();
      seen_bytes = '0;
      htype      = '0;
      ptype      = '0;
      opcode     = '0;
      hlen       = '0;
      plen       = '0;
    endfunction

    function new();
      quick_parse = 1'b0;
      mismatches  = 0;
      clear_packet();
    endfunction

    function void absorb_byte(arp_in_t w);
      arp_out_t    r;
      bit          hit;
      int unsigned off, hl, pl, len, need;
      r   = '0;
      hit = 1'b0;
      case (seen_bytes)
        POS_HTYPE_HI: htype[15:8]  = w.data_byte;
        POS_HTYPE_LO: htype[7:0]   = w.data_byte;
        POS_PTYPE_HI: ptype[15:8]  = w.data_byte;
        POS_PTYPE_LO: ptype[7:0]   = w.data_byte;
        POS_HLEN:     hlen         = w.data_byte;
        POS_PLEN:     plen         = w.data_byte;
        POS_OP_HI:    opcode[15:8] = w.data_byte;
        POS_OP_LO:    opcode[7:0]  = w.data_byte;
        default: begin
          // The four addresses follow the header back to back; anything past
          // them is trailing and yields nothing.
          off = 32'(seen_bytes) - 32'(HDR_LEN);
          hl  = hlen;
          pl  = plen;
          hit = 1'b1;
          if (off < hl) begin
            r.addr_select = SEL_SENDER_HW;
            r.addr_index  = 8'(off);
          end else if (off < hl + pl) begin
            r.addr_select = SEL_SENDER_PROTO;
            r.addr_index  = 8'(off - hl);
          end else if (off < 2 * hl + pl) begin
            r.addr_select = SEL_TARGET_HW;
            r.addr_index  = 8'(off - hl - pl);
          end else if (off < 2 * hl + 2 * pl) begin
            r.addr_select = SEL_TARGET_PROTO;
            r.addr_index  = 8'(off - 2 * hl - pl);
          end else begin
            hit = 1'b0;
          end
        end
      endcase
      if (hit) begin
        r.kind        = KIND_ADDR;
        r.addr_byte   = w.data_byte;
        r.last_result = !w.end_of_packet;
        due = {due, r};
      end

      if (seen_bytes != COUNT_MAX) seen_bytes++;

      if (w.end_of_packet) begin
        r      = '0;
        r.kind = KIND_SUMMARY;
        len    = seen_bytes;
        if (len < 32'(HDR_LEN)) begin
          // A truncated header reports nothing but the short-header flag.
          r.error_bits[ERR_HDR_SHORT] = 1'b1;
        end else begin
          need         = 8 + 2 * int'(hlen) + 2 * int'(plen);
          r.hw_type    = htype;
          r.proto_type = ptype;
          r.op_code    = opcode;
          r.hw_len     = hlen;
          r.proto_len  = plen;
          if (!quick_parse) begin
            r.error_bits[ERR_HW_TYPE]   = (htype != HTYPE_ETHERNET);
            r.error_bits[ERR_PROTO]     = (ptype != PTYPE_IPV4);
            r.error_bits[ERR_HLEN]      = (hlen != HLEN_ETHERNET);
            r.error_bits[ERR_PLEN]      = (plen != PLEN_IPV4);
            r.error_bits[ERR_OP]        = (opcode != OP_REQUEST && opcode != OP_REPLY);
            r.error_bits[ERR_PAY_SHORT] = (len < need);
          end
        end
        r.last_result = 1'b1;
        due = {due, r};
        clear_packet();
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(arp_out_t got);
      arp_out_t want;
      if (due.size() == 0) begin
        $error("result word with nothing expected: kind %0b", got.kind);
        mismatches++;
        return;
      end
      want = due.pop_front();
      compare_field("kind",        16'(want.kind),        16'(got.kind));
      compare_field("addr_select", 16'(want.addr_select), 16'(got.addr_select));
      compare_field("addr_index",  16'(want.addr_index),  16'(got.addr_index));
      compare_field("addr_byte",   16'(want.addr_byte),   16'(got.addr_byte));
      compare_field("hw_type",     want.hw_type,          got.hw_type);
      compare_field("proto_type",  want.proto_type,       got.proto_type);
      compare_field("op_code",     want.op_code,          got.op_code);
      compare_field("hw_len",      16'(want.hw_len),      16'(got.hw_len));
      compare_field("proto_len",   16'(want.proto_len),   16'(got.proto_len));
      compare_field("error_bits",  16'(want.error_bits),  16'(got.error_bits));
      compare_field("last_result", 16'(want.last_result), 16'(got.last_result));
    endfunction
  endclass

  // The limit leaves a wide margin over the slowest correct run, for the long
  // hold-off and for stall-heavy seeds.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  // Cycles to let a word that yields no result clear the pipeline before a
  // configuration write.
  localparam int unsigned SETTLE_CYCLES = 8;

  logic     clk         = 1'b0;
  logic     rst_n       = 1'b0;
  logic     cfg_wr_en   = 1'b0;
  logic     cfg_wr_data = 1'b0;
  logic     in_valid    = 1'b0;
  logic     in_ready;
  arp_in_t  in_data     = '0;
  logic     out_valid;
  logic     out_ready   = 1'b0;
  arp_out_t out_data;

  arp_result_tracker tracker = new();

  int unsigned cycles        = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned mode_left     = 0;
  int unsigned stall_pct     = 0;

  arp_header_parser i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result word ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver. Every word taken at an edge is checked straight away. The ready
  // pattern switches between stretches of steady acceptance and stretches of
  // light or heavy random stalling. When the stimulus asks for a hold-off, ready
  // stays low for a long count kept here, so that the result queue fills and the
  // block must push back on its input.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(5, 60);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          default: stall_pct = 70;
        endcase
      end
      mode_left--;
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offers one byte and returns once the block has taken it. The sender works in
  // bursts; a gap with valid low may only open at the start of a burst, so valid
  // never drops while a word is waiting to be accepted.
  task automatic send_byte(input logic [7:0] b, input logic eop);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_packet: eop};
    do @(posedge clk); while (!in_ready);
    tracker.absorb_byte('{data_byte: b, end_of_packet: eop});
    burst_left--;
  endtask

  task automatic send_packet(input octet_q_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Builds a packet with the given header, random address contents and the given
  // number of trailing bytes; a non-zero cut truncates it to that many bytes.
  function automatic void make_packet(output octet_q_t pkt,
                                      input logic [15:0] ht, pt, op,
                                      input logic [7:0] hl, pl,
                                      input int unsigned extra, cut);
    logic [63:0] hdr;
    int unsigned total;
    hdr   = {ht, pt, hl, pl, op};
    total = 8 + 2 * int'(hl) + 2 * int'(pl) + extra;
    pkt.delete();
    for (int i = 0; i < 8; i++) pkt = {pkt, hdr[63 - 8 * i -: 8]};
    while (pkt.size() < total) pkt = {pkt, 8'($urandom)};
    if (cut != 0) while (pkt.size() > cut) void'(pkt.pop_back());
  endfunction

  // Drops valid, waits for every predicted word and lets the pipeline settle.
  task automatic go_idle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_quick_parse(input logic v);
    go_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.quick_parse = v;
  endtask

  task automatic directed_packets(input bit with_long);
    octet_q_t pkt;
    // End of packet on the very first byte, then a header one byte short.
    pkt = '{8'hFF};
    send_packet(pkt);
    make_packet(pkt, HTYPE_ETHERNET, PTYPE_IPV4, OP_REQUEST, HLEN_ETHERNET, PLEN_IPV4, 0, 7);
    send_packet(pkt);
    // A bare header with empty addresses is complete at eight bytes.
    make_packet(pkt, HTYPE_ETHERNET, PTYPE_IPV4, OP_REQUEST, 8'd0, 8'd0, 0, 0);
    send_packet(pkt);
    // Standard request, ending on the last target address byte, and a reply with
    // trailing bytes that must be ignored.
    make_packet(pkt, HTYPE_ETHERNET, PTYPE_IPV4, OP_REQUEST, HLEN_ETHERNET, PLEN_IPV4, 0, 0);
    send_packet(pkt);
    make_packet(pkt, HTYPE_ETHERNET, PTYPE_IPV4, OP_REPLY, HLEN_ETHERNET, PLEN_IPV4, 3, 0);
    send_packet(pkt);
    // Every header check failing, with extreme field values, then a bad opcode alone.
    make_packet(pkt, 16'hFFFF, 16'h0000, 16'h0000, 8'd1, 8'd0, 0, 0);
    send_packet(pkt);
    make_packet(pkt, 16'h0000, 16'hFFFF, 16'hFFFF, 8'd0, 8'd2, 1, 0);
    send_packet(pkt);
    make_packet(pkt, HTYPE_ETHERNET, PTYPE_IPV4, 16'd3, HLEN_ETHERNET, PLEN_IPV4, 0, 0);
    send_packet(pkt);
    // Payload cut off in the middle of the sender protocol address.
    make_packet(pkt, HTYPE_ETHERNET, PTYPE_IPV4, OP_REQUEST, HLEN_ETHERNET, PLEN_IPV4, 0, 16);
    send_packet(pkt);
    if (with_long) begin
      // Largest address lengths: the whole sender hardware address runs to index
      // 254, and the packet stops a few bytes into the sender protocol address.
      make_packet(pkt, HTYPE_ETHERNET, PTYPE_IPV4, OP_REPLY, 8'd255, 8'd255, 0, 266);
      send_packet(pkt);
    end
  endtask

  // Mostly well-formed packets with random content; the rest are corrupted
  // headers, odd address lengths, truncated payloads, short headers and noise.
  task automatic random_packets(input int unsigned budget);
    octet_q_t    pkt;
    int unsigned sent, pick;
    logic [15:0] op, ht, pt;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      op   = $urandom_range(0, 1) ? OP_REPLY : OP_REQUEST;
      ht   = $urandom_range(0, 1) ? HTYPE_ETHERNET : 16'($urandom);
      pt   = $urandom_range(0, 1) ? PTYPE_IPV4 : 16'($urandom);
      if (pick < 55) begin
        make_packet(pkt, HTYPE_ETHERNET, PTYPE_IPV4, op, HLEN_ETHERNET, PLEN_IPV4,
                    ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0, 0);
      end else if (pick < 65) begin
        make_packet(pkt, HTYPE_ETHERNET, PTYPE_IPV4, op, HLEN_ETHERNET, PLEN_IPV4, 0, 0);
        pkt[$urandom_range(0, 7)] = 8'($urandom);
      end else if (pick < 78) begin
        make_packet(pkt, ht, pt, 16'($urandom), 8'($urandom_range(0, 5)),
                    8'($urandom_range(0, 5)), $urandom_range(0, 3), 0);
      end else if (pick < 86) begin
        make_packet(pkt, HTYPE_ETHERNET, PTYPE_IPV4, op, HLEN_ETHERNET, PLEN_IPV4, 0,
                    $urandom_range(8, 27));
      end else if (pick < 92) begin
        make_packet(pkt, ht, pt, 16'($urandom), 8'($urandom), 8'($urandom), 0,
                    $urandom_range(1, 7));
      end else begin
        pkt.delete();
        repeat ($urandom_range(1, 40)) pkt = {pkt, 8'($urandom)};
      end
      send_packet(pkt);
      sent += pkt.size();
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Checks enabled.
    write_quick_parse(1'b0);
    directed_packets(1'b1);
    random_packets(50);

    // Quick parse: only the short-header flag may survive. The long receiver
    // hold-off lands after the directed packets, while the sender keeps offering.
    write_quick_parse(1'b1);
    directed_packets(1'b0);
    hold_requests++;
    random_packets(40);

    // Back to full checking.
    write_quick_parse(1'b0);
    random_packets(30);

    go_idle();
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/arp_hp_pkg.sv
hdl/arp_header_parser.sv
dv/tb.sv
